// File: rtl/assert_macros.svh
// Assertion macros used by the port-level checker.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an expression at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/u8drs_pkg.sv
// Shared types, constants and class functions of the UTF-8 direction run splitter.
// Depends on nothing; the front end, queue, back end and top level import it.
package u8drs_pkg;

    localparam longint unsigned MAX_LINE_BYTES = 64'd65535;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam int POS_W = 16;
    localparam int CP_W  = 21;

    typedef logic [POS_W-1:0] pos_t;
    typedef logic [CP_W-1:0]  cp_t;

    localparam pos_t POS_LIMIT = pos_t'((MAX_LINE_BYTES < 64'd65535) ?
                                        MAX_LINE_BYTES : 64'd65535);

    typedef struct packed {
        logic is_strong;
        logic rtl;
        pos_t cp_start;
        pos_t pos;
        logic last;
    } event_t;

    typedef struct packed {
        logic last;
        logic rtl;
        pos_t length;
        pos_t start;
    } run_t;

    typedef enum logic {
        PH_EVENT,
        PH_FINAL
    } phase_t;

    function automatic logic class_rtl(input cp_t cp);
        return (cp >= 21'h000590 && cp <= 21'h0008FF) ||
               (cp >= 21'h00FB1D && cp <= 21'h00FDFF) ||
               (cp >= 21'h00FE70 && cp <= 21'h00FEFF);
    endfunction

    function automatic logic class_ltr(input cp_t cp);
        return (cp >= 21'h000041 && cp <= 21'h00005A) ||
               (cp >= 21'h000061 && cp <= 21'h00007A) ||
               (cp >= 21'h000030 && cp <= 21'h000039) ||
               (cp >= 21'h000400 && cp <= 21'h00052F) ||
               (cp >= 21'h00AC00 && cp <= 21'h00D7AF);
    endfunction

endpackage

// File: rtl/u8drs_front.sv
// Front end: accepts line bytes, decodes UTF-8 and classes each code point.
// Depends on u8drs_pkg; pushes strong and line-end events into u8drs_queue.
module u8drs_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        in_byte,
    input  logic              in_last,
    input  logic              q_full,
    output logic              push,
    output u8drs_pkg::event_t push_ev
);
    import u8drs_pkg::*;

    pos_t       pos_reg, pos_next;
    pos_t       seq_start_reg, seq_start_next;
    logic [1:0] exp_reg, exp_next;
    logic [1:0] col_reg, col_next;
    cp_t        cp_reg, cp_next;

    logic       accept;
    logic       cp_valid;
    cp_t        cp_val;
    pos_t       cp_at;
    cp_t        cp_join;
    logic [1:0] col_inc;
    logic       cp_strong;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign cp_join  = {cp_reg[CP_W-7:0], in_byte[5:0]};
    assign col_inc  = col_reg + 2'd1;

    always_comb
    begin
        pos_next       = pos_reg;
        seq_start_next = seq_start_reg;
        exp_next       = exp_reg;
        col_next       = col_reg;
        cp_next        = cp_reg;
        cp_valid       = 1'b0;
        cp_val         = cp_t'(in_byte);
        cp_at          = pos_reg;
        if (exp_reg != 2'd0 && in_byte[7:6] == 2'b10)
        begin
            if (col_inc == exp_reg)
            begin
                cp_valid = 1'b1;
                cp_val   = cp_join;
                cp_at    = seq_start_reg;
                exp_next = 2'd0;
                col_next = 2'd0;
                cp_next  = '0;
            end
            else
            begin
                col_next = col_inc;
                cp_next  = cp_join;
            end
        end
        else
        begin
            exp_next = 2'd0;
            col_next = 2'd0;
            cp_next  = '0;
            if (in_byte[7] == 1'b0)
            begin
                cp_valid = 1'b1;
            end
            else if (in_byte[7:5] == 3'b110)
            begin
                exp_next       = 2'd1;
                cp_next        = cp_t'(in_byte[4:0]);
                seq_start_next = pos_reg;
            end
            else if (in_byte[7:4] == 4'b1110)
            begin
                exp_next       = 2'd2;
                cp_next        = cp_t'(in_byte[3:0]);
                seq_start_next = pos_reg;
            end
            else if (in_byte[7:3] == 5'b11110)
            begin
                exp_next       = 2'd3;
                cp_next        = cp_t'(in_byte[2:0]);
                seq_start_next = pos_reg;
            end
        end
        if (in_last)
        begin
            pos_next       = '0;
            seq_start_next = '0;
            exp_next       = 2'd0;
            col_next       = 2'd0;
            cp_next        = '0;
        end
        else if (pos_reg < POS_LIMIT)
        begin
            pos_next = pos_reg + pos_t'(1);
        end
    end

    assign cp_strong         = cp_valid && (class_rtl(cp_val) || class_ltr(cp_val));
    assign push              = accept && (cp_strong || in_last);
    assign push_ev.is_strong = cp_strong;
    assign push_ev.rtl       = class_rtl(cp_val);
    assign push_ev.cp_start  = cp_at;
    assign push_ev.pos       = pos_reg;
    assign push_ev.last      = in_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            seq_start_reg <= '0;
            exp_reg       <= 2'd0;
            col_reg       <= 2'd0;
            cp_reg        <= '0;
        end
        else if (accept)
        begin
            pos_reg       <= pos_next;
            seq_start_reg <= seq_start_next;
            exp_reg       <= exp_next;
            col_reg       <= col_next;
            cp_reg        <= cp_next;
        end
    end

endmodule

// File: rtl/u8drs_queue.sv
// Event queue between the decoding front end and the run builder.
// Depends on u8drs_pkg for the event type.
module u8drs_queue #(
    parameter int QUEUE_DEPTH = u8drs_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  u8drs_pkg::event_t push_ev,
    output logic              full,
    output logic              head_valid,
    output u8drs_pkg::event_t head_ev,
    input  logic              pop
);
    import u8drs_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    event_t            slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign full       = (count_reg == CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_ev    = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_ev;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: rtl/u8drs_back.sv
// Back end: tracks the open run and emits run requests through an output register.
// Depends on u8drs_pkg; pops events from u8drs_queue.
module u8drs_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  u8drs_pkg::event_t head_ev,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output u8drs_pkg::run_t   out_run
);
    import u8drs_pkg::*;

    phase_t phase_reg, phase_next;
    pos_t   start_reg, start_next;
    logic   rtl_reg, rtl_next;
    logic   known_reg, known_next;
    logic   out_valid_reg, out_valid_next;
    run_t   out_run_reg, out_run_next;

    logic             can_load;
    logic             load;
    logic             flip;
    logic             first;
    run_t             flip_run;
    run_t             final_run;
    logic [POS_W:0]   end_sum;
    logic [POS_W:0]   final_diff;

    assign can_load = !out_valid_reg || out_ready;
    assign flip     = head_ev.is_strong && known_reg && (head_ev.rtl != rtl_reg);
    assign first    = head_ev.is_strong && !known_reg;

    assign end_sum    = {1'b0, head_ev.pos} + (POS_W+1)'(1);
    assign final_diff = end_sum - {1'b0, start_reg};

    always_comb
    begin
        flip_run.start  = start_reg;
        flip_run.length = (head_ev.cp_start >= start_reg) ? head_ev.cp_start - start_reg : '0;
        flip_run.rtl    = rtl_reg;
        flip_run.last   = 1'b0;

        final_run.start = start_reg;
        if (end_sum < {1'b0, start_reg})
        begin
            final_run.length = '0;
        end
        else if (final_diff[POS_W])
        begin
            final_run.length = '1;
        end
        else
        begin
            final_run.length = final_diff[POS_W-1:0];
        end
        final_run.rtl  = (first ? head_ev.rtl : rtl_reg) && (known_reg || first);
        final_run.last = 1'b1;
    end

    always_comb
    begin
        phase_next   = phase_reg;
        start_next   = start_reg;
        rtl_next     = rtl_reg;
        known_next   = known_reg;
        out_run_next = out_run_reg;
        load         = 1'b0;
        pop          = 1'b0;
        case (phase_reg)
            PH_EVENT:
            begin
                if (head_valid)
                begin
                    if (flip)
                    begin
                        if (can_load)
                        begin
                            load         = 1'b1;
                            out_run_next = flip_run;
                            start_next   = head_ev.cp_start;
                            rtl_next     = head_ev.rtl;
                            if (head_ev.last)
                            begin
                                phase_next = PH_FINAL;
                            end
                            else
                            begin
                                pop = 1'b1;
                            end
                        end
                    end
                    else if (head_ev.last)
                    begin
                        if (can_load)
                        begin
                            load         = 1'b1;
                            out_run_next = final_run;
                            pop          = 1'b1;
                            start_next   = '0;
                            rtl_next     = 1'b0;
                            known_next   = 1'b0;
                        end
                    end
                    else
                    begin
                        pop = 1'b1;
                        if (first)
                        begin
                            rtl_next   = head_ev.rtl;
                            known_next = 1'b1;
                        end
                    end
                end
            end
            PH_FINAL:
            begin
                if (can_load)
                begin
                    load         = 1'b1;
                    out_run_next = final_run;
                    pop          = 1'b1;
                    start_next   = '0;
                    rtl_next     = 1'b0;
                    known_next   = 1'b0;
                    phase_next   = PH_EVENT;
                end
            end
            default:
            begin
                phase_next = PH_EVENT;
            end
        endcase
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_run   = out_run_reg;

    always_ff @(posedge clk)
    begin
        out_run_reg <= out_run_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_EVENT;
            start_reg     <= '0;
            rtl_reg       <= 1'b0;
            known_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            start_reg     <= start_next;
            rtl_reg       <= rtl_next;
            known_reg     <= known_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: rtl/utf8_direction_run_splitter_unit.sv
// Top level of the UTF-8 direction run splitter: front end, event queue, back end.
// Depends on u8drs_pkg, u8drs_front, u8drs_queue and u8drs_back.
//
//   channel | direction | tdata                          | tuser   | tlast
//   s_*     | in        | text_byte                      | -       | line_end
//   m_*     | out       | run_start, run_length          | run_rtl | run_last
//
// One byte per cycle is taken while the event queue has room.
// A byte that ends a line and flips direction gives two runs, one per cycle
// from the back end while m_tready is high, which sets the peak output rate of one run per cycle.
// A byte's event is registered in the event queue, and its run then in the output register.
// A stalled output fills the queue, and then s_tready drops.
// Reset clears all control state at once; no clearing pass is needed.
module utf8_direction_run_splitter_unit #(
    parameter int QUEUE_DEPTH = u8drs_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] text_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [15:0] run_start, [31:16] run_length
    output logic        m_tuser,    // [0] run_rtl
    output logic        m_tlast
);
    import u8drs_pkg::*;

    logic   push;
    event_t push_ev;
    logic   q_full;
    logic   head_valid;
    event_t head_ev;
    logic   pop;
    run_t   out_run;

    u8drs_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .in_last  (s_tlast),
        .q_full   (q_full),
        .push     (push),
        .push_ev  (push_ev)
    );

    u8drs_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ev    (push_ev),
        .full       (q_full),
        .head_valid (head_valid),
        .head_ev    (head_ev),
        .pop        (pop)
    );

    u8drs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_ev    (head_ev),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_run    (out_run)
    );

    assign m_tdata = {out_run.length, out_run.start};
    assign m_tuser = out_run.rtl;
    assign m_tlast = out_run.last;

endmodule

// File: rtl/u8drs_checker.sv
// Port-level checker for the UTF-8 direction run splitter, bound to the top level.
// Depends on assert_macros.svh and the top-level port list.
`include "assert_macros.svh"

module u8drs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);
    logic        open_reg, open_next;
    logic [15:0] end_reg, end_next;
    logic        rtl_reg, rtl_next;
    logic        out_take;
    logic [16:0] span;

    assign out_take = m_tvalid && m_tready;
    assign span     = {1'b0, m_tdata[15:0]} + {1'b0, m_tdata[31:16]};

    always_comb
    begin
        open_next = open_reg;
        end_next  = end_reg;
        rtl_next  = rtl_reg;
        if (out_take)
        begin
            open_next = !m_tlast;
            end_next  = span[15:0];
            rtl_next  = m_tuser;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 1'b0;
            end_reg  <= '0;
            rtl_reg  <= 1'b0;
        end
        else
        begin
            open_reg <= open_next;
            end_reg  <= end_next;
            rtl_reg  <= rtl_next;
        end
    end

    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast),
        "output request changed while stalled")

    `ASSERT_IMPLIES(a_span_in_line, clk, rst_n, m_tvalid, span <= 17'h10000,
        "run reaches past the end of a line")

    `ASSERT_IMPLIES(a_line_starts_at_zero, clk, rst_n, m_tvalid && !open_reg,
        m_tdata[15:0] == 16'd0, "first run of a line does not start at offset zero")

    `ASSERT_IMPLIES(a_runs_adjoin, clk, rst_n, m_tvalid && open_reg,
        m_tdata[15:0] == end_reg && m_tuser != rtl_reg,
        "run does not follow the previous run or keeps its direction")

endmodule

bind utf8_direction_run_splitter_unit u8drs_checker u_checker (.*);
